/* rtl/deq_pkg.sv */
// ----------------------------------------------------------------------------
// Double-ended queue package
// Sizes, types, request and status codes, and ring pointer helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

  localparam int DEPTH     = 1024;
  localparam int WORD_BITS = 32;
  localparam int PTR_BITS  = $clog2(DEPTH);
  localparam int CNT_BITS  = $clog2(DEPTH + 1);

  typedef logic [PTR_BITS-1:0]  ptr_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;
  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [2:0]           action_t;
  typedef logic [1:0]           status_t;

  localparam action_t ACT_PUSH_FRONT = 3'd0;
  localparam action_t ACT_PUSH_BACK  = 3'd1;
  localparam action_t ACT_POP_FRONT  = 3'd2;
  localparam action_t ACT_POP_BACK   = 3'd3;
  localparam action_t ACT_PEEK       = 3'd4;

  localparam status_t ST_DONE  = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  localparam ptr_t  PTR_LAST = ptr_t'(DEPTH - 1);
  localparam cnt_t  CNT_FULL = cnt_t'(DEPTH);
  localparam word_t WORD_NONE = '1;

  function automatic ptr_t ptr_inc(input ptr_t p);
    return (p == PTR_LAST) ? '0 : p + ptr_t'(1);
  endfunction

  function automatic ptr_t ptr_dec(input ptr_t p);
    return (p == '0) ? PTR_LAST : p - ptr_t'(1);
  endfunction

endpackage

`default_nettype wire

/* rtl/deq_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/double_ended_queue_top.sv */
// ----------------------------------------------------------------------------
// Double-ended queue top level
// Ring store in RAM with head, tail and count; front and back words cached.
// ----------------------------------------------------------------------------
// A push, a peek, a refused push or a pop on an empty queue has its result
// registered at the edge that takes the request. A pop that leaves at least
// one word passes through S_READ first, since the new end word is fetched
// from the ring RAM, whose read data is registered. Each request yields one result,
// held in an output register; a new request is taken only while the block
// is idle and that register is free or being emptied in the same cycle.
// Ring contents are not cleared after reset, and no entry is read before it
// has been written.
`default_nettype none

module double_ended_queue_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         action,
  input  wire logic signed [31:0] value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      popped,
  output logic [1:0]              status,
  output logic [10:0]             occupancy,
  output logic                    is_empty,
  output logic signed [31:0]      front_word,
  output logic signed [31:0]      back_word
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t state;
  deq_pkg::ptr_t  head, head_next;
  deq_pkg::ptr_t  tail, tail_next;
  deq_pkg::cnt_t  count, count_next;
  deq_pkg::word_t front_reg, front_next;
  deq_pkg::word_t back_reg, back_next;
  logic           read_back;
  logic           read_back_next;

  logic             accept;
  logic             need_read;
  deq_pkg::status_t st;
  deq_pkg::word_t   pop_word;
  logic             wr_en, rd_en;
  deq_pkg::ptr_t    wr_addr, rd_addr;
  deq_pkg::word_t   rd_data;

  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    head_next      = head;
    tail_next      = tail;
    count_next     = count;
    front_next     = front_reg;
    back_next      = back_reg;
    st             = deq_pkg::ST_DONE;
    pop_word       = deq_pkg::WORD_NONE;
    wr_en          = 1'b0;
    wr_addr        = head;
    rd_en          = 1'b0;
    rd_addr        = head;
    need_read      = 1'b0;
    read_back_next = 1'b0;
    case (action)
      deq_pkg::ACT_PUSH_FRONT: begin
        if (count == deq_pkg::CNT_FULL) begin
          st = deq_pkg::ST_FULL;
        end else begin
          head_next  = deq_pkg::ptr_dec(head);
          wr_en      = accept;
          wr_addr    = head_next;
          front_next = value;
          if (count == '0) begin
            back_next = value;
          end
          count_next = count + deq_pkg::cnt_t'(1);
        end
      end
      deq_pkg::ACT_PUSH_BACK: begin
        if (count == deq_pkg::CNT_FULL) begin
          st = deq_pkg::ST_FULL;
        end else begin
          tail_next = deq_pkg::ptr_inc(tail);
          wr_en     = accept;
          wr_addr   = tail;
          back_next = value;
          if (count == '0) begin
            front_next = value;
          end
          count_next = count + deq_pkg::cnt_t'(1);
        end
      end
      deq_pkg::ACT_POP_FRONT: begin
        if (count == '0) begin
          st = deq_pkg::ST_EMPTY;
        end else begin
          pop_word   = front_reg;
          head_next  = deq_pkg::ptr_inc(head);
          count_next = count - deq_pkg::cnt_t'(1);
          // The new front word lives in the RAM unless the queue went empty.
          need_read  = (count_next != '0);
          rd_en      = accept && need_read;
          rd_addr    = head_next;
        end
      end
      deq_pkg::ACT_POP_BACK: begin
        if (count == '0) begin
          st = deq_pkg::ST_EMPTY;
        end else begin
          pop_word       = back_reg;
          tail_next      = deq_pkg::ptr_dec(tail);
          count_next     = count - deq_pkg::cnt_t'(1);
          need_read      = (count_next != '0);
          read_back_next = 1'b1;
          rd_en          = accept && need_read;
          rd_addr        = deq_pkg::ptr_dec(tail_next);
        end
      end
      default: begin
        // Peek and the unused codes leave the queue as it is.
      end
    endcase
  end

  deq_ram #(
    .WIDTH(deq_pkg::WORD_BITS),
    .DEPTH(deq_pkg::DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            head  <= head_next;
            tail  <= tail_next;
            count <= count_next;
            // Any earlier result has been taken by now.
            if (need_read) begin
              state     <= S_READ;
              out_valid <= 1'b0;
            end else begin
              out_valid <= 1'b1;
            end
          end else if (out_valid && !out_stall) begin
            out_valid <= 1'b0;
          end
        end
        S_READ: begin
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Cached end words and the result register.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept) begin
      front_reg <= front_next;
      back_reg  <= back_next;
      read_back <= read_back_next;
      popped    <= pop_word;
      status    <= st;
      occupancy <= count_next;
      is_empty  <= (count_next == '0);
      if (count_next == '0) begin
        front_word <= deq_pkg::WORD_NONE;
        back_word  <= deq_pkg::WORD_NONE;
      end else begin
        front_word <= front_next;
        back_word  <= back_next;
      end
    end else if (state == S_READ) begin
      if (read_back) begin
        back_reg   <= rd_data;
        back_word  <= rd_data;
        front_word <= front_reg;
      end else begin
        front_reg  <= rd_data;
        front_word <= rd_data;
        back_word  <= back_reg;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/deq_checker.sv */
// ----------------------------------------------------------------------------
// Double-ended queue checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic signed [31:0] popped,
  input wire logic [1:0]         status,
  input wire logic [10:0]        occupancy,
  input wire logic               is_empty,
  input wire logic signed [31:0] front_word,
  input wire logic signed [31:0] back_word
);

  // A stalled result holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(popped) && $stable(status)
      && $stable(occupancy) && $stable(front_word) && $stable(back_word))
    else $error("stalled result changed");

  // The empty flag agrees with the count.
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> is_empty == (occupancy == 11'd0))
    else $error("empty flag disagrees with occupancy");

  // An empty queue reports -1 at both ends.
  a_empty_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_empty |-> front_word == -32'sd1 && back_word == -32'sd1)
    else $error("empty queue reports an end word");

  // A pop on an empty queue leaves it empty and returns -1.
  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == deq_pkg::ST_EMPTY |-> is_empty && popped == -32'sd1)
    else $error("bad result for pop on empty queue");

  // A push is refused only when the queue is full.
  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == deq_pkg::ST_FULL
      |-> occupancy == 11'(deq_pkg::DEPTH) && popped == -32'sd1)
    else $error("push refused while not full");

endmodule

bind double_ended_queue_top deq_checker u_deq_checker (.*);

`default_nettype wire

/* dv/tb_double_ended_queue_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue testbench
// Sends push, pop and peek requests and keeps a mirror of the ring store.
// Each result is checked field by field against the mirror's prediction.
// The receiver stalls at random and at one point holds off for a long time.
// ----------------------------------------------------------------------------
module tb_double_ended_queue_top;

  // Codes above peek are treated as a peek by the block.
  localparam deq_pkg::action_t ACT_ALIAS_FIRST = 3'd5;
  localparam deq_pkg::action_t ACT_ALIAS_LAST  = 3'd7;
  localparam int               HOLD_CYCLES     = 300;
  localparam int               DRAIN_CYCLES    = 8;

  typedef struct {
    deq_pkg::word_t   popped;
    deq_pkg::status_t status;
    deq_pkg::cnt_t    occupancy;
    logic             is_empty;
    deq_pkg::word_t   front_word;
    deq_pkg::word_t   back_word;
  } deq_result_t;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic [2:0]         action    = deq_pkg::ACT_PEEK;
  logic signed [31:0] value     = '0;
  logic               out_stall = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic signed [31:0] popped;
  logic [1:0]         status;
  logic [10:0]        occupancy;
  logic               is_empty;
  logic signed [31:0] front_word;
  logic signed [31:0] back_word;

  deq_pkg::word_t mirror_ring [deq_pkg::DEPTH];
  deq_pkg::ptr_t  mirror_head  = '0;
  deq_pkg::ptr_t  mirror_tail  = '0;
  deq_pkg::cnt_t  mirror_count = '0;
  deq_result_t    expected_results [$];

  int error_count    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req       = 0;
  int hold_seen      = 0;
  int hold_left      = 0;

  double_ended_queue_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .popped     (popped),
    .status     (status),
    .occupancy  (occupancy),
    .is_empty   (is_empty),
    .front_word (front_word),
    .back_word  (back_word)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic deq_result_t predict_deque_step(deq_pkg::action_t act,
                                                     deq_pkg::word_t val);
    deq_result_t   r;
    deq_pkg::ptr_t back_ptr;
    r.popped = deq_pkg::WORD_NONE;
    r.status = deq_pkg::ST_DONE;
    case (act)
      deq_pkg::ACT_PUSH_FRONT, deq_pkg::ACT_PUSH_BACK: begin
        if (mirror_count == deq_pkg::CNT_FULL) begin
          r.status = deq_pkg::ST_FULL;
        end else if (act == deq_pkg::ACT_PUSH_FRONT) begin
          mirror_head = (mirror_head == '0) ? deq_pkg::PTR_LAST : mirror_head - 1'b1;
          mirror_ring[mirror_head] = val;
          mirror_count = mirror_count + 1'b1;
        end else begin
          mirror_ring[mirror_tail] = val;
          mirror_tail = (mirror_tail == deq_pkg::PTR_LAST) ? '0 : mirror_tail + 1'b1;
          mirror_count = mirror_count + 1'b1;
        end
      end
      deq_pkg::ACT_POP_FRONT, deq_pkg::ACT_POP_BACK: begin
        if (mirror_count == '0) begin
          r.status = deq_pkg::ST_EMPTY;
        end else if (act == deq_pkg::ACT_POP_FRONT) begin
          r.popped = mirror_ring[mirror_head];
          mirror_head = (mirror_head == deq_pkg::PTR_LAST) ? '0 : mirror_head + 1'b1;
          mirror_count = mirror_count - 1'b1;
        end else begin
          mirror_tail = (mirror_tail == '0) ? deq_pkg::PTR_LAST : mirror_tail - 1'b1;
          r.popped = mirror_ring[mirror_tail];
          mirror_count = mirror_count - 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.occupancy = mirror_count;
    r.is_empty  = (mirror_count == '0);
    if (mirror_count == '0) begin
      r.front_word = deq_pkg::WORD_NONE;
      r.back_word  = deq_pkg::WORD_NONE;
    end else begin
      back_ptr     = (mirror_tail == '0) ? deq_pkg::PTR_LAST : mirror_tail - 1'b1;
      r.front_word = mirror_ring[mirror_head];
      r.back_word  = mirror_ring[back_ptr];
    end
    return r;
  endfunction

  task automatic report_failure(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_failure($sformatf("%s: got %0h, expected %0h", name, got, want));
    end
  endtask

  // Called in the time step of a rising edge; returns at the edge that
  // accepted the request.
  task automatic send_request(deq_pkg::action_t act, deq_pkg::word_t val);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    value    <= val;
    do begin
      @(negedge clk);
    end while (in_stall);
    expected_results = {expected_results, predict_deque_step(act, val)};
    @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (expected_results.size() != 0);
  endtask

  function automatic deq_pkg::action_t pick_action(int push_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return deq_pkg::action_t'($urandom_range(ACT_ALIAS_FIRST, ACT_ALIAS_LAST));
    if (r < 10) return deq_pkg::ACT_PEEK;
    if ($urandom_range(0, 99) < push_pct) begin
      return $urandom_range(0, 1) ? deq_pkg::ACT_PUSH_BACK : deq_pkg::ACT_PUSH_FRONT;
    end
    return $urandom_range(0, 1) ? deq_pkg::ACT_POP_BACK : deq_pkg::ACT_POP_FRONT;
  endfunction

  function automatic deq_pkg::word_t pick_word();
    case ($urandom_range(0, 19))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Results are sampled at the falling edge and taken at the next rising edge.
  always @(negedge clk) begin
    deq_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_failure($sformatf("result with nothing expected, popped %0h", popped));
      end else begin
        want = expected_results[0];
        expected_results.delete(0);
        check_field("popped", popped, want.popped);
        check_field("status", 32'(status), 32'(want.status));
        check_field("occupancy", 32'(occupancy), 32'(want.occupancy));
        check_field("is_empty", 32'(is_empty), 32'(want.is_empty));
        check_field("front_word", front_word, want.front_word);
        check_field("back_word", back_word, want.back_word);
      end
    end
  end

  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    out_stall <= !rst && (hold_left != 0 || $urandom_range(0, 99) < recv_stall_pct);
  end

  task automatic test_empty_queue();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_request(deq_pkg::ACT_POP_FRONT, $urandom);
    send_request(deq_pkg::ACT_POP_BACK, $urandom);
    send_request(deq_pkg::ACT_PEEK, $urandom);
    for (int a = int'(ACT_ALIAS_FIRST); a <= int'(ACT_ALIAS_LAST); a++) begin
      send_request(deq_pkg::action_t'(a), $urandom);
    end
  endtask

  task automatic test_edge_words();
    send_request(deq_pkg::ACT_PUSH_BACK, 32'h7FFF_FFFF);
    send_request(deq_pkg::ACT_PUSH_FRONT, 32'h8000_0000);
    send_request(deq_pkg::ACT_PUSH_BACK, '0);
    send_request(deq_pkg::ACT_PUSH_FRONT, '1);
    send_request(deq_pkg::ACT_PEEK, 32'h1234_5678);
    send_request(deq_pkg::ACT_POP_FRONT, $urandom);
    send_request(deq_pkg::ACT_POP_BACK, $urandom);
    send_request(deq_pkg::ACT_PUSH_BACK, 32'h5555_5555);
    send_request(deq_pkg::ACT_PUSH_FRONT, 32'hAAAA_AAAA);
    send_request(ACT_ALIAS_LAST, $urandom);
    send_request(deq_pkg::ACT_POP_BACK, $urandom);
    send_request(deq_pkg::ACT_POP_BACK, $urandom);
    send_request(deq_pkg::ACT_POP_FRONT, $urandom);
    send_request(deq_pkg::ACT_POP_FRONT, $urandom);
    send_request(deq_pkg::ACT_POP_BACK, $urandom);
    send_request(deq_pkg::ACT_POP_FRONT, $urandom);
  endtask

  // Fills the ring from both ends until pushes are refused, trims a few
  // words off the ends and tops it up again. The queue is left full
  // for the tests that follow.
  task automatic test_fill_and_refuse();
    send_idle_pct  = 10;
    recv_stall_pct = 10;
    for (int i = 0; i < deq_pkg::DEPTH; i++) begin
      send_request($urandom_range(0, 1) ? deq_pkg::ACT_PUSH_BACK : deq_pkg::ACT_PUSH_FRONT,
                   $urandom);
    end
    send_request(deq_pkg::ACT_PUSH_FRONT, $urandom);
    send_request(deq_pkg::ACT_PUSH_BACK, $urandom);
    send_request(deq_pkg::ACT_PEEK, $urandom);
    for (int i = 0; i < 8; i++) begin
      send_request($urandom_range(0, 1) ? deq_pkg::ACT_POP_BACK : deq_pkg::ACT_POP_FRONT,
                   $urandom);
    end
    for (int i = 0; i < 9; i++) begin
      send_request($urandom_range(0, 1) ? deq_pkg::ACT_PUSH_BACK : deq_pkg::ACT_PUSH_FRONT,
                   pick_word());
    end
  endtask

  // The receiver holds off while requests keep coming, so the output
  // register stays full and the block must stall its input.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req <= hold_req + 1;
    for (int i = 0; i < 40; i++) begin
      send_request(pick_action(60), pick_word());
    end
  endtask

  // Push-heavy and pop-heavy stretches alternate so that the occupancy
  // wanders below and back up to full.
  task automatic test_random_phase(int idle_pct, int stall_pct, int count);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      send_request(pick_action(((i / 25) % 2 == 0) ? 30 : 70), pick_word());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_queue();
    wait_drained();
    test_edge_words();
    wait_drained();
    test_fill_and_refuse();
    wait_drained();
    test_backpressure();
    wait_drained();
    test_random_phase(0, 0, 50);
    test_random_phase(45, 0, 50);
    test_random_phase(0, 45, 50);
    test_random_phase(25, 25, 50);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
